// ===== src/filtered_message_queue_top_macros.svh =====
// Assertion macros used by the queue top level.
`ifndef FILTERED_MESSAGE_QUEUE_TOP_MACROS_SVH
`define FILTERED_MESSAGE_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define FMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

// ===== src/fmq_pkg.sv =====
// Types and constants shared by the queue cells and the top level.
package fmq_pkg;

  localparam int TYPE_W        = 16;
  localparam int HANDLE_W      = 32;
  localparam int FLEN_W        = 4;
  localparam int FILTER_FIELDS = 4;
  localparam int IN_TDATA_W    = 120;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic                                   get;
    logic [TYPE_W-1:0]                      entry_type;
    logic [HANDLE_W-1:0]                    entry_handle;
    logic signed [FLEN_W-1:0]               filter_length;
    logic [FILTER_FIELDS-1:0][TYPE_W-1:0]   filter_type;
  } req_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                                   eval;
    logic                                   apply_put;
    logic                                   apply_get;
    logic                                   pass_any;
    logic                                   exclude;
    logic [FILTER_FIELDS-1:0]               type_en;
    logic [FILTER_FIELDS-1:0][TYPE_W-1:0]   filter_type;
    logic [TYPE_W-1:0]                      put_type;
    logic [HANDLE_W-1:0]                    put_handle;
  } cell_ctrl_t;

endpackage

// ===== src/filtered_message_queue_top.sv =====
// Message queue with filtered removal, built as a row of shifting slot cells.
//
//   channel   dir   tdata / tuser contents
//   s_*       in    requests: put entry at tail or get first entry passing filter
//   m_*       out   results: accepted flag, removed entry, occupancy
//
// An item goes through accept, filter evaluation in every cell, then the tail write
// for a put, or the priority pick and shift along the cell row for a get. A new item is
// accepted in the cycle after the result is registered; the block takes no new item
// until the previous one has been applied. The apply cycle waits while the previous result is still held on m_*.
// Reset clears the occupancy count and the sequencer; slot contents are not cleared.
`include "filtered_message_queue_top_macros.svh"

module filtered_message_queue_top
  import fmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_FILTER  = 4,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_BITS    = 1 + TYPE_W + HANDLE_W + CNT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // entry_type, entry_handle, filter_length, filter_type_0..filter_type_3
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accepted, found_type, found_handle, occupancy
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int LIMIT = (MAX_FILTER < FILTER_FIELDS) ? MAX_FILTER : FILTER_FIELDS;

  state_t             state;
  state_t             state_next;
  req_t               req_q;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               in_go;
  logic               eval_go;
  logic               apply_go;
  logic               acc_q;
  logic [TYPE_W-1:0]  type_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CNT_W-1:0]   occ_q;
  logic               res_acc;
  logic [TYPE_W-1:0]  res_type;
  logic [HANDLE_W-1:0] res_handle;
  logic [FLEN_W-1:0]  mag_raw;
  logic [FLEN_W-1:0]  mag;
  cell_ctrl_t         ctrl;

  logic                hit   [0:QUEUE_DEPTH];
  logic [TYPE_W-1:0]   f_type   [0:QUEUE_DEPTH];
  logic [HANDLE_W-1:0] f_handle [0:QUEUE_DEPTH];
  logic [TYPE_W-1:0]   s_type   [0:QUEUE_DEPTH];
  logic [HANDLE_W-1:0] s_handle [0:QUEUE_DEPTH];

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_APPLY;
      ST_APPLY: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    s_tready = 1'b0;
    eval_go  = 1'b0;
    apply_go = 1'b0;
    case (state)
      ST_IDLE:  s_tready = !rst;
      ST_EVAL:  eval_go  = 1'b1;
      ST_APPLY: apply_go = !m_tvalid || m_tready;
      default:  s_tready = 1'b0;
    endcase
  end

  assign in_go = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      req_q.get           <= s_tuser;
      req_q.entry_type    <= s_tdata[15:0];
      req_q.entry_handle  <= s_tdata[47:16];
      req_q.filter_length <= s_tdata[51:48];
      req_q.filter_type   <= s_tdata[115:52];
    end
  end

  // Filter decode: magnitude saturates to the usable list length, sign picks exclude.
  assign mag_raw = req_q.filter_length[FLEN_W-1] ? (FLEN_W'(0) - req_q.filter_length)
                                                 : req_q.filter_length;
  assign mag     = (mag_raw > FLEN_W'(LIMIT)) ? FLEN_W'(LIMIT) : mag_raw;

  always_comb begin
    ctrl.eval        = eval_go;
    ctrl.apply_put   = apply_go & (req_q.get == REQ_PUT);
    ctrl.apply_get   = apply_go & (req_q.get == REQ_GET);
    ctrl.pass_any    = req_q.filter_length == '0;
    ctrl.exclude     = req_q.filter_length[FLEN_W-1];
    ctrl.filter_type = req_q.filter_type;
    ctrl.put_type    = req_q.entry_type;
    ctrl.put_handle  = req_q.entry_handle;
    for (int j = 0; j < FILTER_FIELDS; j++) begin
      ctrl.type_en[j] = FLEN_W'(j) < mag;
    end
  end

  assign hit[0]                = 1'b0;
  assign f_type[0]             = '0;
  assign f_handle[0]           = '0;
  assign s_type[QUEUE_DEPTH]   = '0;
  assign s_handle[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    fmq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .count          (count),
      .hit_in         (hit[i]),
      .hit_out        (hit[i+1]),
      .nbr_type       (s_type[i+1]),
      .nbr_handle     (s_handle[i+1]),
      .fnd_type_in    (f_type[i]),
      .fnd_handle_in  (f_handle[i]),
      .fnd_type_out   (f_type[i+1]),
      .fnd_handle_out (f_handle[i+1]),
      .slot_type      (s_type[i]),
      .slot_handle    (s_handle[i])
    );
  end

  always_comb begin
    count_next = count;
    res_type   = '0;
    res_handle = '0;
    if (req_q.get == REQ_PUT) begin
      res_acc = count < CNT_W'(QUEUE_DEPTH);
      if (res_acc) begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      res_acc    = hit[QUEUE_DEPTH];
      res_type   = f_type[QUEUE_DEPTH];
      res_handle = f_handle[QUEUE_DEPTH];
      if (res_acc) begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (apply_go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      acc_q    <= res_acc;
      type_q   <= res_type;
      handle_q <= res_handle;
      occ_q    <= count_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'({occ_q, handle_q, type_q, acc_q});

  `FMQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `FMQ_ASSERT_NEXT(a_result_shown, apply_go, m_tvalid)
  `FMQ_ASSERT_NOW(a_refused_zero, m_tvalid && !acc_q, type_q == '0 && handle_q == '0)
  `FMQ_ASSERT_NEXT(a_occ_tracks, apply_go, occ_q == count)
  `FMQ_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

// ===== src/fmq_cell.sv =====
// One queue slot: holds an entry, tests it against the filter and shifts toward the head.
module fmq_cell
  import fmq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]    count,
  input  logic                hit_in,
  output logic                hit_out,
  input  logic [TYPE_W-1:0]   nbr_type,
  input  logic [HANDLE_W-1:0] nbr_handle,
  input  logic [TYPE_W-1:0]   fnd_type_in,
  input  logic [HANDLE_W-1:0] fnd_handle_in,
  output logic [TYPE_W-1:0]   fnd_type_out,
  output logic [HANDLE_W-1:0] fnd_handle_out,
  output logic [TYPE_W-1:0]   slot_type,
  output logic [HANDLE_W-1:0] slot_handle
);

  logic [TYPE_W-1:0]   type_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                pass_q;
  logic                live;
  logic                listed;
  logic                sel;
  logic                take;

  assign live = CNT_W'(IDX) < count;

  always_comb begin
    listed = 1'b0;
    for (int j = 0; j < FILTER_FIELDS; j++) begin
      if (ctrl.type_en[j] && (ctrl.filter_type[j] == type_q)) begin
        listed = 1'b1;
      end
    end
  end

  // The first passing cell is the one whose left neighbors all failed.
  assign hit_out = hit_in | pass_q;
  assign sel     = pass_q & ~hit_in;
  assign take    = hit_in | pass_q;

  assign fnd_type_out   = fnd_type_in | (sel ? type_q : '0);
  assign fnd_handle_out = fnd_handle_in | (sel ? handle_q : '0);
  assign slot_type      = type_q;
  assign slot_handle    = handle_q;

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      pass_q <= live & (ctrl.pass_any | (ctrl.exclude ^ listed));
    end
    if (ctrl.apply_put && (count == CNT_W'(IDX))) begin
      type_q   <= ctrl.put_type;
      handle_q <= ctrl.put_handle;
    end else if (ctrl.apply_get && take) begin
      type_q   <= nbr_type;
      handle_q <= nbr_handle;
    end
  end

endmodule

// ===== sim/filtered_message_queue_top_test.sv =====
// Self-checking testbench for the filtered message queue: directed table, then random traffic.
module filtered_message_queue_top_test;
  import fmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_FILTER  = 4;
  localparam int LIST_LIMIT  = (MAX_FILTER < FILTER_FIELDS) ? MAX_FILTER : FILTER_FIELDS;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_BITS    = 1 + TYPE_W + HANDLE_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 190;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic                accepted;
    logic [TYPE_W-1:0]   found_type;
    logic [HANDLE_W-1:0] found_handle;
    logic [CNT_W-1:0]    occupancy;
  } queue_result_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   msg_type;
    logic [HANDLE_W-1:0] msg_handle;
  } slot_entry_t;

  typedef struct {
    req_t          req;
    bit            typed_in;
    queue_result_t want;
  } table_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  slot_entry_t   held_entries[$];
  queue_result_t expected_results[$];
  table_row_t    directed_rows[$];
  logic [TYPE_W-1:0] type_pool[6];
  int error_count  = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int rx_tick      = 0;
  int rx_mode      = 0;

  filtered_message_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_FILTER (MAX_FILTER)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Applies one request to the local copy of the queue and returns its result.
  function automatic queue_result_t step_queue(input req_t r);
    queue_result_t res;
    bit exclude;
    bit hit;
    int span;
    int pick;
    res = '0;
    pick = -1;
    if (r.get == REQ_PUT) begin
      if (held_entries.size() < QUEUE_DEPTH) begin
        held_entries.push_back('{msg_type: r.entry_type, msg_handle: r.entry_handle});
        res.accepted = 1'b1;
      end
    end else begin
      exclude = (r.filter_length < 0);
      span = exclude ? -int'(r.filter_length) : int'(r.filter_length);
      if (span > LIST_LIMIT) span = LIST_LIMIT;
      for (int i = 0; i < held_entries.size() && pick < 0; i++) begin
        hit = 1'b0;
        for (int k = 0; k < span; k++) begin
          if (r.filter_type[k] == held_entries[i].msg_type) hit = 1'b1;
        end
        if (r.filter_length == 0 || hit != exclude) pick = i;
      end
      if (pick >= 0) begin
        res.accepted     = 1'b1;
        res.found_type   = held_entries[pick].msg_type;
        res.found_handle = held_entries[pick].msg_handle;
        held_entries.delete(pick);
      end
    end
    res.occupancy = CNT_W'(held_entries.size());
    return res;
  endfunction

  function automatic void add_row(input logic get, input logic [TYPE_W-1:0] etype,
                                  input logic [HANDLE_W-1:0] ehandle,
                                  input logic signed [FLEN_W-1:0] flen,
                                  input logic [TYPE_W-1:0] f0, input logic [TYPE_W-1:0] f1,
                                  input logic [TYPE_W-1:0] f2, input logic [TYPE_W-1:0] f3,
                                  input bit typed_in, input queue_result_t want);
    table_row_t row;
    row.req.get           = get;
    row.req.entry_type    = etype;
    row.req.entry_handle  = ehandle;
    row.req.filter_length = flen;
    row.req.filter_type   = {f3, f2, f1, f0};
    row.typed_in          = typed_in;
    row.want              = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_table();
    logic [TYPE_W-1:0] t;
    // Get on the empty queue right after reset.
    add_row(REQ_GET, '0, '0, 4'sd0, '0, '0, '0, '0, 1, '{1'b0, 16'h0, 32'h0, 5'd0});
    add_row(REQ_PUT, 16'h0000, 32'h0000_0000, 4'sd0, '1, '1, '1, '1,
            1, '{1'b1, 16'h0, 32'h0, 5'd1});
    add_row(REQ_PUT, 16'hFFFF, 32'hFFFF_FFFF, -4'sd8, '0, '0, '0, '0,
            1, '{1'b1, 16'h0, 32'h0, 5'd2});
    add_row(REQ_GET, 16'hFFFF, 32'hFFFF_FFFF, 4'sd1, 16'hFFFF, '0, '0, '0,
            1, '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 5'd1});
    // Most negative length excludes all four listed zeros, so nothing passes.
    add_row(REQ_GET, '0, '0, -4'sd8, '0, '0, '0, '0, 1, '{1'b0, 16'h0, 32'h0, 5'd1});
    // Length 7 saturates to four, which reaches the zero in the last field.
    add_row(REQ_GET, '0, '0, 4'sd7, 16'h0001, 16'h0002, 16'h0003, 16'h0000,
            1, '{1'b1, 16'h0, 32'h0, 5'd0});
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      t = TYPE_W'(i * 'h1111);
      add_row(REQ_PUT, t, {~t, t}, 4'sd0, '0, '0, '0, '0, 0, '0);
    end
    add_row(REQ_PUT, 16'hABCD, 32'h1234_5678, 4'sd0, '0, '0, '0, '0,
            1, '{1'b0, 16'h0, 32'h0, 5'd16});
    add_row(REQ_GET, '0, '0, 4'sd4, 16'h7777, 16'h3333, 16'hABCD, 16'hBEEF, 0, '0);
    add_row(REQ_GET, '0, '0, -4'sd2, 16'h0000, 16'h1111, '0, '0, 0, '0);
    add_row(REQ_GET, '0, '0, 4'sd0, 16'h5555, '0, '0, '0, 0, '0);
    // Only the first three listed types count, so the match in the fourth is ignored.
    add_row(REQ_GET, '0, '0, 4'sd3, 16'h1234, 16'h5678, 16'h9ABC, 16'h4444, 0, '0);
    add_row(REQ_GET, '0, '0, -4'sd1, 16'h1111, '0, '0, '0, 0, '0);
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(0, 99) < 85) return type_pool[$urandom_range(0, 5)];
    return TYPE_W'($urandom);
  endfunction

  function automatic req_t random_request(input int put_pct);
    req_t r;
    r.get           = ($urandom_range(0, 99) < put_pct) ? REQ_PUT : REQ_GET;
    r.entry_type    = pick_type();
    r.entry_handle  = $urandom;
    r.filter_length = FLEN_W'($urandom_range(0, 15));
    for (int k = 0; k < FILTER_FIELDS; k++) r.filter_type[k] = pick_type();
    return r;
  endfunction

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic pace_sender(input bit allow_gaps);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (allow_gaps) idle_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic issue_request(input req_t r, input bit typed_in, input queue_result_t want);
    queue_result_t predicted;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= r.get;
    s_tdata  <= {{(IN_TDATA_W - 116){1'b0}}, r.filter_type, r.filter_length,
                 r.entry_handle, r.entry_type};
    do @(posedge clk); while (!s_tready);
    predicted = step_queue(r);
    expected_results.push_back(typed_in ? want : predicted);
  endtask

  task automatic wait_for_drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver back-pressure: a randomly redrawn rx_mode picks one of four ready patterns.
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= ($urandom_range(0, 99) < 60);
      end
      2: begin
        m_tready <= (rx_tick % 4 == 0);
      end
      default: begin
        m_tready <= (rx_tick % 16) >= 12;
      end
    endcase
  end

  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.accepted     = m_tdata[0];
      got.found_type   = m_tdata[TYPE_W:1];
      got.found_handle = m_tdata[TYPE_W+HANDLE_W:TYPE_W+1];
      got.occupancy    = m_tdata[TYPE_W+HANDLE_W+CNT_W:TYPE_W+HANDLE_W+1];
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result %h arrived with nothing expected", m_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted)
          report_failure($sformatf("accepted: got %b expected %b", got.accepted, want.accepted));
        if (got.found_type !== want.found_type)
          report_failure($sformatf("found_type: got %h expected %h",
                                   got.found_type, want.found_type));
        if (got.found_handle !== want.found_handle)
          report_failure($sformatf("found_handle: got %h expected %h",
                                   got.found_handle, want.found_handle));
        if (got.occupancy !== want.occupancy)
          report_failure($sformatf("occupancy: got %0d expected %0d",
                                   got.occupancy, want.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int put_bias[6];
    put_bias = '{70, 30, 55, 85, 15, 50};
    type_pool[0] = 16'h0000;
    type_pool[1] = 16'hFFFF;
    for (int k = 2; k < 6; k++) type_pool[k] = TYPE_W'($urandom);
    build_directed_table();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pace_sender(1'b1);
      issue_request(directed_rows[i].req, directed_rows[i].typed_in, directed_rows[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Phase 3 streams back to back without sender gaps.
        pace_sender(p != 3);
        issue_request(random_request(put_bias[p]), 1'b0, '0);
      end
      if (p == 1) begin
        // Hold the sender until the queue has returned every result.
        idle_sender(1);
        wait_for_drain();
      end
    end

    idle_sender(1);
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fmq_pkg.sv
src/fmq_cell.sv
src/filtered_message_queue_top.sv
sim/filtered_message_queue_top_test.sv
